// ===== rtl/text_console_writer_defines.svh =====
// assertion macros shared by the console modules
// each one samples on i_clk and is held off while i_rst_n is low
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    // field widths of the transaction payloads
    localparam int KIND_W  = 1;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;

    // transaction kinds
    localparam logic [KIND_W-1:0] KIND_PUT  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_READ = 1'b1;

    // control characters and the blank cell
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] BLANK_ATTR = 8'h07;

    // input transaction
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAR_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic [INDEX_W-1:0] cursor_pos;
        logic [CHAR_W-1:0]  cell_char;
        logic [CHAR_W-1:0]  cell_attr;
    } t_out_item;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic clr_run;
        logic scr_run;
        logic load_out;
    } t_ctl_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic scroll_req;
        logic clr_last;
        logic scr_last;
    } t_ctl_sts;

endpackage

`default_nettype wire

// ===== rtl/tcw_datapath.sv =====
`default_nettype none
`include "text_console_writer_defines.svh"

module tcw_datapath #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tcw_pkg::t_in_item   i_in_data,
    input  wire tcw_pkg::t_ctl_cmd   i_cmd,
    output tcw_pkg::t_ctl_sts        o_sts,
    output tcw_pkg::t_out_item       o_out_data
);

    localparam int CELLS = COLS * ROWS;
    localparam int MW    = $clog2(CELLS);
    localparam int AW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLS);

    localparam logic [MW-1:0] LAST_ROW  = MW'(CELLS - COLS);
    localparam logic [MW-1:0] LAST_CELL = MW'(CELLS - 1);
    localparam logic [MW-1:0] ROW_STEP  = MW'(COLS);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);
    localparam logic [AW-1:0] CNT_CLR   = AW'(CELLS - 1);
    localparam logic [AW-1:0] CNT_SCR   = AW'(CELLS);
    localparam logic [AW:0]   SCR_LIMIT = (AW + 1)'(CELLS);
    localparam logic [AW:0]   SCR_STEP  = (AW + 1)'(COLS);

    // screen store, character and attribute planes
    logic [tcw_pkg::CHAR_W-1:0] mem_char [CELLS];
    logic [tcw_pkg::CHAR_W-1:0] mem_attr [CELLS];

    // cursor kept as position, column and row start
    logic [MW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_col, n_col;
    logic [MW-1:0] r_row_start, n_row_start;
    logic          r_scroll_req;
    logic          scroll_now;

    // sweep counter for clearing and scrolling
    logic [AW-1:0] r_cnt;
    logic          r_scr_rd_ok;
    logic [AW:0]   scr_rd_idx;
    logic          scr_rd_ok;
    logic [AW-1:0] cnt_m1;

    // memory port controls
    logic                       wr_en_char;
    logic                       wr_en_attr;
    logic [MW-1:0]              wr_addr;
    logic [tcw_pkg::CHAR_W-1:0] wr_char;
    logic [tcw_pkg::CHAR_W-1:0] wr_attr;
    logic                       rd_en;
    logic [MW-1:0]              rd_addr;
    logic [tcw_pkg::CHAR_W-1:0] r_rd_char;
    logic [tcw_pkg::CHAR_W-1:0] r_rd_attr;

    // read transaction decode
    logic        put;
    logic        is_read;
    logic [31:0] idx_ext;
    logic        idx_hit;
    logic        r_rd_hit;

    assign put     = i_cmd.accept && (i_in_data.kind == tcw_pkg::KIND_PUT);
    assign is_read = i_cmd.accept && (i_in_data.kind == tcw_pkg::KIND_READ);
    assign idx_ext = 32'(i_in_data.cell_index);
    assign idx_hit = idx_ext < 32'(CELLS);

    assign scr_rd_idx = {1'b0, r_cnt} + SCR_STEP;
    assign scr_rd_ok  = scr_rd_idx < SCR_LIMIT;
    assign cnt_m1     = r_cnt - AW'(1);

    // cursor movement for a put transaction
    always_comb begin
        n_pos       = r_pos;
        n_col       = r_col;
        n_row_start = r_row_start;
        scroll_now  = 1'b0;
        if (put) begin
            case (i_in_data.char_code)
                tcw_pkg::CH_CR: begin
                    n_pos = r_row_start;
                    n_col = '0;
                end
                tcw_pkg::CH_LF: begin
                    n_col = '0;
                    if (r_row_start == LAST_ROW) begin
                        n_pos      = LAST_ROW;
                        scroll_now = 1'b1;
                    end else begin
                        n_pos       = r_row_start + ROW_STEP;
                        n_row_start = r_row_start + ROW_STEP;
                    end
                end
                tcw_pkg::CH_BS: begin
                    if (r_pos != '0) begin
                        n_pos = r_pos - MW'(1);
                        if (r_col == '0) begin
                            n_col       = COL_LAST;
                            n_row_start = r_row_start - ROW_STEP;
                        end else begin
                            n_col = r_col - CW'(1);
                        end
                    end
                end
                default: begin
                    if (r_pos == LAST_CELL) begin
                        n_pos       = LAST_ROW;
                        n_col       = '0;
                        n_row_start = LAST_ROW;
                        scroll_now  = 1'b1;
                    end else begin
                        n_pos = r_pos + MW'(1);
                        if (r_col == COL_LAST) begin
                            n_col       = '0;
                            n_row_start = r_row_start + ROW_STEP;
                        end else begin
                            n_col = r_col + CW'(1);
                        end
                    end
                end
            endcase
        end
    end

    // write port selection
    always_comb begin
        wr_en_char = 1'b0;
        wr_en_attr = 1'b0;
        wr_addr    = r_pos;
        wr_char    = tcw_pkg::BLANK_CHAR;
        wr_attr    = tcw_pkg::BLANK_ATTR;
        if (i_cmd.clr_run) begin
            wr_en_char = 1'b1;
            wr_en_attr = 1'b1;
            wr_addr    = r_cnt[MW-1:0];
        end else if (i_cmd.scr_run) begin
            wr_en_char = (r_cnt != '0);
            wr_en_attr = (r_cnt != '0);
            wr_addr    = cnt_m1[MW-1:0];
            if (r_scr_rd_ok) begin
                wr_char = r_rd_char;
                wr_attr = r_rd_attr;
            end
        end else if (put) begin
            wr_en_char = 1'b1;
            if (i_in_data.char_code == tcw_pkg::CH_BS) begin
                wr_en_attr = 1'b1;
            end else if (i_in_data.char_code != tcw_pkg::CH_CR
                         && i_in_data.char_code != tcw_pkg::CH_LF) begin
                wr_char = i_in_data.char_code;
            end else begin
                wr_en_char = 1'b0;
            end
        end
    end

    // read port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_ext[MW-1:0];
        if (i_cmd.scr_run) begin
            rd_en   = scr_rd_ok;
            rd_addr = scr_rd_idx[MW-1:0];
        end else if (is_read) begin
            rd_en = idx_hit;
        end
    end

    // screen store write
    always_ff @(posedge i_clk) begin
        if (wr_en_char) begin
            mem_char[wr_addr] <= wr_char;
        end
        if (wr_en_attr) begin
            mem_attr[wr_addr] <= wr_attr;
        end
    end

    // screen store registered read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_char <= mem_char[rd_addr];
            r_rd_attr <= mem_attr[rd_addr];
        end
    end

    // cursor, sweep counter and scroll request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_col        <= '0;
            r_row_start  <= '0;
            r_cnt        <= '0;
            r_scroll_req <= 1'b0;
            r_scr_rd_ok  <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_col       <= n_col;
            r_row_start <= n_row_start;
            r_scr_rd_ok <= i_cmd.scr_run && scr_rd_ok;
            if (i_cmd.clr_run) begin
                r_cnt <= o_sts.clr_last ? '0 : r_cnt + AW'(1);
            end else if (i_cmd.scr_run) begin
                r_cnt <= o_sts.scr_last ? '0 : r_cnt + AW'(1);
            end
            if (put) begin
                r_scroll_req <= scroll_now;
            end else if (i_cmd.scr_run && o_sts.scr_last) begin
                r_scroll_req <= 1'b0;
            end
        end
    end

    // read hit flag for the pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_hit <= is_read && idx_hit;
        end
    end

    // output transaction register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out_data.cursor_pos <= tcw_pkg::INDEX_W'(r_pos);
            o_out_data.cell_char  <= r_rd_hit ? r_rd_char : '0;
            o_out_data.cell_attr  <= r_rd_hit ? r_rd_attr : '0;
        end
    end

    assign o_sts.scroll_req = r_scroll_req;
    assign o_sts.clr_last   = (r_cnt == CNT_CLR);
    assign o_sts.scr_last   = (r_cnt == CNT_SCR);

    `TCW_ASSERT_NOW(a_pos_in_range, 1'b1, r_pos <= LAST_CELL, "cursor past the last cell")
    `TCW_ASSERT_NOW(a_pos_split, 1'b1, r_pos == r_row_start + MW'(r_col), "cursor split broken")

endmodule

`default_nettype wire

// ===== rtl/tcw_ctrl.sv =====
`default_nettype none
`include "text_console_writer_defines.svh"

module tcw_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    input  wire tcw_pkg::t_ctl_sts i_sts,
    output tcw_pkg::t_ctl_cmd      o_cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESULT,
        ST_SCROLL
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall;
    logic   r_out_valid;
    logic   out_free;
    logic   out_take;

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_take = r_out_valid && !i_out_stall;

    // commands to the datapath
    always_comb begin
        o_cmd.accept   = i_in_valid && !r_in_stall;
        o_cmd.clr_run  = (r_state == ST_CLEAR);
        o_cmd.scr_run  = (r_state == ST_SCROLL);
        o_cmd.load_out = (r_state == ST_RESULT) && !i_sts.scroll_req && out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_cmd.accept) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (i_sts.scroll_req) begin
                    n_state = ST_SCROLL;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCROLL: begin
                if (i_sts.scr_last) begin
                    n_state = ST_RESULT;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_in_stall  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != ST_IDLE);
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

    `TCW_ASSERT_NOW(a_accept_idle, o_cmd.accept, r_state == ST_IDLE, "accept outside idle")
    `TCW_ASSERT_NEXT(a_stall_after_accept, o_cmd.accept, r_in_stall, "no stall after accept")
    `TCW_ASSERT_NOW(a_load_free, o_cmd.load_out, !r_out_valid || !i_out_stall, "result overrun")
    `TCW_ASSERT_NEXT(a_scroll_end, o_cmd.scr_run && i_sts.scr_last, r_state == ST_RESULT, "scroll exit")

endmodule

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
`default_nettype none
// channel | valid      | stall       | payload
// input   | i_in_valid | o_in_stall  | i_in_data  (kind, char_code, cell_index)
// output  | o_out_valid| i_out_stall | o_out_data (cursor_pos, cell_char, cell_attr)
//
// an item without scroll is accepted, then loaded into the output register once it is free
// a put that reaches the end of the screen scrolls the store up by one row,
// one cell moved a cycle through the single write port of the screen store
// after reset a clearing pass blanks the store, input stalled
// a result waiting in the output register holds the next one in the controller

module text_console_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tcw_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tcw_pkg::t_out_item      o_out_data
);

    tcw_pkg::t_ctl_cmd cmd;
    tcw_pkg::t_ctl_sts sts;

    // sequencing of clear, transactions and scroll
    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // cursor, screen store and result register
    tcw_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
    import tcw_pkg::*;

    localparam int COLS             = 80;
    localparam int ROWS             = 25;
    localparam int CELLS            = COLS * ROWS;
    localparam int GAP_MAX          = 14;
    localparam int IDLE_LIMIT       = 8000;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int RANDOM_ITEMS     = 420;
    localparam int TAIL_CYCLES      = 20;
    localparam logic [15:0] BLANK_CELL = {BLANK_ATTR, BLANK_CHAR};
    localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'h20;
    localparam logic [CHAR_W-1:0] LAST_PRINTABLE  = 8'h7E;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    // shadow of the console: cursor and screen store
    logic [15:0] screen_copy [CELLS];
    int unsigned cursor_copy;

    // console outputs still owed by the block, oldest first
    t_out_item pending_console_out[$];

    int  mismatches  = 0;
    int  idle_cycles = 0;
    int  stall_left  = 0;
    bit  in_quiet    = 1'b0;
    bit  out_quiet   = 1'b0;

    text_console_writer #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always #10 clk = ~clk;

    // shadow console behaviour
    function automatic void blank_console();
        cursor_copy = 0;
        for (int i = 0; i < CELLS; i++) screen_copy[i] = BLANK_CELL;
    endfunction

    // cursor move, scrolling one row when it runs off the end
    function automatic void land_cursor(int unsigned pos);
        if (pos >= CELLS) begin
            for (int i = 0; i + COLS < CELLS; i++) screen_copy[i] = screen_copy[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen_copy[i] = BLANK_CELL;
            pos = pos - COLS;
            if (pos >= CELLS) pos = CELLS - COLS;
        end
        cursor_copy = pos;
    endfunction

    function automatic t_out_item console_step(t_in_item item);
        t_out_item   res;
        int unsigned pos;
        res = '0;
        if (item.kind == KIND_PUT) begin
            pos = (cursor_copy >= CELLS) ? 0 : cursor_copy;
            case (item.char_code)
                CH_CR: land_cursor(pos - pos % COLS);
                CH_LF: land_cursor(pos - pos % COLS + COLS);
                CH_BS: begin
                    screen_copy[pos] = BLANK_CELL;
                    land_cursor(pos >= 1 ? pos - 1 : 0);
                end
                default: begin
                    screen_copy[pos][7:0] = item.char_code;
                    land_cursor(pos + 1);
                end
            endcase
        end else if (item.cell_index < CELLS) begin
            res.cell_char = screen_copy[item.cell_index][7:0];
            res.cell_attr = screen_copy[item.cell_index][15:8];
        end
        res.cursor_pos = cursor_copy[INDEX_W-1:0];
        return res;
    endfunction

    // compare one output transaction with the oldest owed one
    function automatic void check_console_out(t_out_item got);
        t_out_item want;
        if (pending_console_out.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("unexpected output: cursor %0d char %h attr %h",
                         got.cursor_pos, got.cell_char, got.cell_attr);
            return;
        end
        want = pending_console_out.pop_front();
        if (got.cursor_pos !== want.cursor_pos || got.cell_char !== want.cell_char ||
            got.cell_attr !== want.cell_attr) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("mismatch: cursor exp %0d got %0d, char exp %h got %h, attr exp %h got %h",
                         want.cursor_pos, got.cursor_pos, want.cell_char, got.cell_char,
                         want.cell_attr, got.cell_attr);
        end
    endfunction

    // output side: check each transaction and draw a stall after it
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                check_console_out(out_data);
                stall_left = out_quiet ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("text_console_writer regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in_item put_item(logic [CHAR_W-1:0] code);
        t_in_item item;
        item.kind       = KIND_PUT;
        item.char_code  = code;
        item.cell_index = INDEX_W'($urandom_range(0, 2047));
        return item;
    endfunction

    function automatic t_in_item read_item(int unsigned idx);
        t_in_item item;
        item.kind       = KIND_READ;
        item.char_code  = CHAR_W'($urandom_range(0, 255));
        item.cell_index = INDEX_W'(idx);
        return item;
    endfunction

    function automatic logic [CHAR_W-1:0] printable();
        return CHAR_W'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE));
    endfunction

    // one input transaction after a random gap
    task automatic send_item(t_in_item item);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        pending_console_out.push_back(console_step(item));
    endtask

    // hold off input until every owed output has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_console_out.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // cells right after the clearing pass, in range and past the end
    task automatic test_reset_contents();
        send_item(read_item(0));
        send_item(read_item(CELLS - 1));
        send_item(read_item(CELLS));
        send_item(read_item(2047));
        send_item(read_item(1365));
    endtask

    // ordinary codes write the character byte only
    task automatic test_plain_chars();
        send_item(put_item(8'h41));
        send_item(put_item(8'hFF));
        send_item(put_item(8'h00));
        send_item(put_item(8'h80));
        send_item(read_item(1));
        send_item(read_item(2));
    endtask

    // backspace blanks and steps back, sticking at zero
    task automatic test_backspace();
        send_item(put_item(CH_BS));
        send_item(put_item(CH_BS));
        send_item(read_item(3));
        send_item(put_item(CH_BS));
        send_item(put_item(CH_BS));
        send_item(put_item(CH_BS));
        send_item(read_item(0));
    endtask

    task automatic test_cr_lf();
        send_item(put_item(8'h78));
        send_item(put_item(CH_CR));
        send_item(put_item(CH_LF));
        send_item(put_item(8'h79));
        send_item(put_item(CH_LF));
        send_item(put_item(CH_CR));
        send_item(read_item(COLS));
    endtask

    // line feeds down to the last row and one more to scroll
    task automatic test_scroll_by_line_feed();
        send_item(put_item(8'h51));
        while (cursor_copy / COLS != ROWS - 1) send_item(put_item(CH_LF));
        send_item(put_item(CH_LF));
        send_item(read_item(0));
        send_item(read_item(COLS));
        send_item(read_item(CELLS - COLS - 1));
        send_item(read_item(CELLS - COLS));
    endtask

    // mixed text, control codes and reads with idle and busy stretches
    task automatic test_random_text();
        int          pick;
        int unsigned back;
        t_in_item    item;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                in_quiet  = ($urandom_range(0, 3) == 0);
                out_quiet = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                item = put_item(printable());
            end else if (pick < 48) begin
                item = put_item(CHAR_W'($urandom_range(0, 255)));
            end else if (pick < 58) begin
                item = put_item(CH_LF);
            end else if (pick < 62) begin
                item = put_item(CH_CR);
            end else if (pick < 70) begin
                item = put_item(CH_BS);
            end else if (pick < 84) begin
                // recently written cells, current row and the one above
                back = $urandom_range(0, COLS + 10);
                item = read_item(cursor_copy > back ? cursor_copy - back : 0);
            end else if (pick < 94) begin
                item = read_item($urandom_range(0, CELLS - 1));
            end else begin
                item = read_item($urandom_range(CELLS, 2047));
            end
            send_item(item);
        end
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
    endtask

    // a full last row of text so the last cell write scrolls
    task automatic test_line_wrap();
        send_item(put_item(CH_CR));
        while (cursor_copy / COLS != ROWS - 1) send_item(put_item(CH_LF));
        for (int i = 0; i < COLS; i++) send_item(put_item(printable()));
        for (int i = 0; i < 8; i++)
            send_item(read_item($urandom_range(CELLS - 2 * COLS, CELLS - COLS - 1)));
        send_item(read_item($urandom_range(CELLS - COLS, CELLS - 1)));
    endtask

    initial begin
        blank_console();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_contents();
        test_plain_chars();
        test_backspace();
        test_cr_lf();
        test_scroll_by_line_feed();
        drain_results();
        test_random_text();
        test_line_wrap();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("text_console_writer regression: pass");
        end else begin
            $display("text_console_writer regression: fail");
        end
        $finish;
    end

endmodule
